// ----- hdl/btnf_pkg.sv -----
// Shared types and constants of the boundary-tag next-fit allocator.
`default_nettype none
package btnf_pkg;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHECK,
        S_A_EVAL,
        S_F_HDR,
        S_F_PREV,
        S_F_NEXT,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd        command;
        logic [14:0] request_size;
        logic [14:0] block_address;
    } t_item;

    typedef struct packed {
        logic        ok;
        logic [14:0] payload_address;
    } t_result;

    localparam int FIRST_PAYLOAD = 32;
    localparam int MIN_BLOCK     = 32;
    localparam int WR_SLOTS      = 4;

endpackage
`default_nettype wire

// ----- hdl/btnf_tag_ram.sv -----
// Tag memory: one write port, one read port, registered read data.
`default_nettype none
module btnf_tag_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_idx,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_idx,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_idx];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/btnf_ctrl.sv -----
// Allocator sequencer: clearing sweep, next-fit walk, free with merge, tag writes.
`default_nettype none
module btnf_ctrl
    import btnf_pkg::*;
#(
    parameter int HEAP_BYTES = 32768,
    parameter int AW         = 12,
    parameter int TW         = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_item         i_item,
    output logic               o_idle,
    output logic               o_done,
    input  wire logic          i_taken,
    output t_result            o_result,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_widx,
    output logic [TW-1:0]      o_mem_wdata,
    output logic               o_mem_re,
    output logic [AW-1:0]      o_mem_ridx,
    input  wire logic [TW-1:0] i_mem_rdata
);

    localparam int WORDS    = HEAP_BYTES / 8;
    localparam int NW       = AW + 1;
    localparam int BW       = ($clog2(HEAP_BYTES) + 2 > 17) ? $clog2(HEAP_BYTES) + 2 : 17;
    localparam int HEAP_END_I = HEAP_BYTES - (HEAP_BYTES % 16);
    localparam logic [BW-1:0] HEAP_END = BW'(HEAP_END_I);
    localparam logic [BW-1:0] FIRST_P  = BW'(FIRST_PAYLOAD);
    localparam logic [BW-1:0] MIN_B    = BW'(MIN_BLOCK);
    localparam logic [AW-1:0] EPI_IDX  = AW'(HEAP_END_I / 8 - 1);
    localparam logic [AW-1:0] FTR_IDX  = AW'((HEAP_END_I - 16) / 8);
    localparam logic [TW-1:0] FREE0    = TW'(HEAP_END_I - 32);
    localparam logic [TW-1:0] PRO_TAG  = TW'(17);
    localparam logic [TW-1:0] EPI_TAG  = TW'(1);

    t_state r_state, n_state;

    logic [BW-1:0] r_a, n_a;
    logic [BW-1:0] r_need, n_need;
    logic [BW-1:0] r_p, n_p;
    logic [BW-1:0] r_limit, n_limit;
    logic [NW-1:0] r_n, n_n;
    logic          r_pass, n_pass;
    logic [BW-1:0] r_rover, n_rover;
    logic [BW-1:0] r_s, n_s;
    logic [BW-1:0] r_ps, n_ps;
    logic          r_pfree, n_pfree;
    t_result       r_res, n_res;
    logic [BW-1:0] r_wa [WR_SLOTS];
    logic [BW-1:0] n_wa [WR_SLOTS];
    logic [TW-1:0] r_wd [WR_SLOTS];
    logic [TW-1:0] n_wd [WR_SLOTS];
    logic [2:0]    r_wcnt, n_wcnt;
    logic [2:0]    r_step, n_step;
    logic          r_rd_oob, n_rd_oob;

    // tag as seen by the logic: a read outside the memory is allocated, size zero
    logic [TW-1:0] rd_tag;
    logic [BW-1:0] tag_size;
    assign rd_tag   = r_rd_oob ? EPI_TAG : i_mem_rdata;
    assign tag_size = BW'({rd_tag[TW-1:3], 3'b000});

    // conditions shared by next-state and datapath
    logic [BW-1:0] req_ext, need_calc, rover_norm;
    logic          pass_end, walk_stop, walk_hit, second_pass;
    logic          free_bad_addr, free_bad_hdr;
    logic [BW-1:0] free_a;

    assign req_ext     = BW'(i_item.request_size);
    assign need_calc   = (req_ext <= BW'(16)) ? MIN_B
                       : (((req_ext + BW'(31)) >> 4) << 4);
    assign rover_norm  = (r_rover >= HEAP_END || r_rover < FIRST_P) ? FIRST_P : r_rover;
    assign pass_end    = (r_n == NW'(WORDS)) || (r_p >= r_limit) || (r_p < FIRST_P);
    assign second_pass = !r_pass && (r_rover != FIRST_P);
    assign walk_stop   = (tag_size == '0) || (r_p + tag_size > HEAP_END);
    assign walk_hit    = !rd_tag[0] && (r_need <= tag_size);
    assign free_a      = BW'(i_item.block_address);
    assign free_bad_addr = (free_a[3:0] != 4'd0) || (free_a < FIRST_P);
    assign free_bad_hdr  = !rd_tag[0] || (tag_size < MIN_B) || (r_a + tag_size > HEAP_END);

    function automatic logic in_mem(input logic [BW-1:0] addr);
        return (addr >> 3) < BW'(WORDS);
    endfunction

    function automatic logic [AW-1:0] word_idx(input logic [BW-1:0] addr);
        return addr[AW+2:3];
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_n == NW'(WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.command == CMD_ALLOC) n_state = S_A_CHECK;
                    else if (free_bad_addr)          n_state = S_DONE;
                    else                             n_state = S_F_HDR;
                end
            end
            S_A_CHECK: begin
                if (pass_end && !second_pass) n_state = S_DONE;
                else if (!pass_end)           n_state = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (walk_stop)     n_state = S_A_CHECK;
                else if (walk_hit) n_state = S_WRITE;
                else               n_state = S_A_CHECK;
            end
            S_F_HDR: begin
                n_state = free_bad_hdr ? S_DONE : S_F_PREV;
            end
            S_F_PREV: n_state = S_F_NEXT;
            S_F_NEXT: n_state = S_WRITE;
            S_WRITE: begin
                if (r_step == r_wcnt) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_taken) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        logic [BW-1:0] rest, ns, nxt, t, m;
        logic          nfree;
        rest = '0; ns = '0; nxt = '0; t = '0; m = '0; nfree = 1'b0;

        n_a = r_a; n_need = r_need; n_p = r_p; n_limit = r_limit; n_n = r_n;
        n_pass = r_pass; n_rover = r_rover; n_s = r_s; n_ps = r_ps; n_pfree = r_pfree;
        n_res = r_res; n_wcnt = r_wcnt; n_step = r_step; n_rd_oob = r_rd_oob;
        for (int i = 0; i < WR_SLOTS; i++) begin
            n_wa[i] = r_wa[i];
            n_wd[i] = r_wd[i];
        end

        o_mem_we = 1'b0; o_mem_widx = '0; o_mem_wdata = '0;
        o_mem_re = 1'b0; o_mem_ridx = '0;

        case (r_state)
            S_CLEAR: begin
                o_mem_we   = 1'b1;
                o_mem_widx = r_n[AW-1:0];
                if (r_n[AW-1:0] == AW'(1) || r_n[AW-1:0] == AW'(2)) o_mem_wdata = PRO_TAG;
                else if (r_n[AW-1:0] == AW'(3) || r_n[AW-1:0] == FTR_IDX)
                    o_mem_wdata = FREE0;
                else if (r_n[AW-1:0] == EPI_IDX) o_mem_wdata = EPI_TAG;
                n_n = r_n + NW'(1);
            end
            S_IDLE: begin
                n_res  = '0;
                n_wcnt = '0;
                n_step = '0;
                if (i_start) begin
                    n_need  = need_calc;
                    n_rover = rover_norm;
                    n_p     = rover_norm;
                    n_limit = HEAP_END;
                    n_n     = '0;
                    n_pass  = 1'b0;
                    n_a     = free_a;
                    if (i_item.command == CMD_FREE && !free_bad_addr) begin
                        n_rover  = r_rover;
                        o_mem_re   = 1'b1;
                        o_mem_ridx = word_idx(free_a - BW'(8));
                        n_rd_oob   = !in_mem(free_a - BW'(8));
                    end
                end
            end
            S_A_CHECK: begin
                if (pass_end) begin
                    // wrap once to the first block, up to the rover
                    n_p     = FIRST_P;
                    n_limit = r_rover;
                    n_n     = '0;
                    n_pass  = 1'b1;
                end else begin
                    o_mem_re   = 1'b1;
                    o_mem_ridx = word_idx(r_p - BW'(8));
                    n_rd_oob   = !in_mem(r_p - BW'(8));
                end
            end
            S_A_EVAL: begin
                if (walk_stop) begin
                    n_n = NW'(WORDS);
                end else if (walk_hit) begin
                    rest    = tag_size - r_need;
                    n_rover = r_p;
                    n_res.ok = 1'b1;
                    n_res.payload_address = r_p[14:0];
                    if (rest >= MIN_B) begin
                        n_wa[0] = r_p - BW'(8);             n_wd[0] = TW'(r_need) | TW'(1);
                        n_wa[1] = r_p + r_need - BW'(16);   n_wd[1] = TW'(r_need) | TW'(1);
                        n_wa[2] = r_p + r_need - BW'(8);    n_wd[2] = TW'(rest);
                        n_wa[3] = r_p + tag_size - BW'(16); n_wd[3] = TW'(rest);
                        n_wcnt  = 3'd4;
                    end else begin
                        n_wa[0] = r_p - BW'(8);             n_wd[0] = TW'(tag_size) | TW'(1);
                        n_wa[1] = r_p + tag_size - BW'(16); n_wd[1] = TW'(tag_size) | TW'(1);
                        n_wcnt  = 3'd2;
                    end
                end else begin
                    n_p = r_p + tag_size;
                    n_n = r_n + NW'(1);
                end
            end
            S_F_HDR: begin
                n_s = tag_size;
                if (!free_bad_hdr) begin
                    o_mem_re   = 1'b1;
                    o_mem_ridx = word_idx(r_a - BW'(16));
                    n_rd_oob   = !in_mem(r_a - BW'(16));
                end
            end
            S_F_PREV: begin
                n_ps    = tag_size;
                n_pfree = !rd_tag[0] && (tag_size != '0) && (tag_size <= r_a - FIRST_P);
                o_mem_re   = 1'b1;
                o_mem_ridx = word_idx(r_a + r_s - BW'(8));
                n_rd_oob   = !in_mem(r_a + r_s - BW'(8));
            end
            S_F_NEXT: begin
                nxt   = r_a + r_s;
                ns    = tag_size;
                nfree = !rd_tag[0] && (ns != '0) && (nxt + ns <= HEAP_END);
                m     = r_a;
                // release the block's own tags first, then merge
                n_wa[0] = r_a - BW'(8);          n_wd[0] = TW'(r_s);
                n_wa[1] = r_a + r_s - BW'(16);   n_wd[1] = TW'(r_s);
                n_wcnt  = 3'd2;
                if (!r_pfree && nfree) begin
                    t = r_s + ns;
                    n_wa[2] = r_a - BW'(8);      n_wd[2] = TW'(t);
                    n_wa[3] = r_a + t - BW'(16); n_wd[3] = TW'(t);
                    n_wcnt  = 3'd4;
                end else if (r_pfree && !nfree) begin
                    t = r_s + r_ps;
                    m = r_a - r_ps;
                    n_wa[2] = r_a + r_s - BW'(16); n_wd[2] = TW'(t);
                    n_wa[3] = m - BW'(8);          n_wd[3] = TW'(t);
                    n_wcnt  = 3'd4;
                end else if (r_pfree && nfree) begin
                    t = r_s + r_ps + ns;
                    m = r_a - r_ps;
                    n_wa[2] = nxt + ns - BW'(16); n_wd[2] = TW'(t);
                    n_wa[3] = m - BW'(8);         n_wd[3] = TW'(t);
                    n_wcnt  = 3'd4;
                end
                if (m < r_rover) n_rover = m;
                n_res.ok = 1'b1;
                n_res.payload_address = m[14:0];
            end
            S_WRITE: begin
                if (r_step != r_wcnt) begin
                    o_mem_we    = in_mem(r_wa[r_step[1:0]]);
                    o_mem_widx  = word_idx(r_wa[r_step[1:0]]);
                    o_mem_wdata = r_wd[r_step[1:0]];
                    n_step      = r_step + 3'd1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rover <= FIRST_P;
            r_n     <= '0;
            r_wcnt  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_rover <= n_rover;
            r_n     <= n_n;
            r_wcnt  <= n_wcnt;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_need   <= n_need;
        r_p      <= n_p;
        r_limit  <= n_limit;
        r_pass   <= n_pass;
        r_s      <= n_s;
        r_ps     <= n_ps;
        r_pfree  <= n_pfree;
        r_res    <= n_res;
        r_rd_oob <= n_rd_oob;
        for (int i = 0; i < WR_SLOTS; i++) begin
            r_wa[i] <= n_wa[i];
            r_wd[i] <= n_wd[i];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/boundary_tag_next_fit_allocator_unit.sv -----
// Allocate walks the block tags from the rover, reading and checking one block at a time,
// wrapping once to the first block up to the rover, then writes two tags (whole block) or
// four (split). Free reads its header, the previous footer and the next header, then writes
// two tags or four (merge); a bad address goes straight to the result, a bad header after its read.
// Flow: one word at a time; the next word is accepted the cycle after the result leaves
// the sequencer, while a finished result waits in the output register.
// Reset: synchronous, active low; after it a clearing sweep over all HEAP_BYTES/8 tag
// words writes the prologue, one free block and the epilogue, and s_axis_tready stays low.
`default_nettype none
module boundary_tag_next_fit_allocator_unit
    import btnf_pkg::*;
#(
    parameter int HEAP_BYTES = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [14:0] request_size, [29:15] block_address, zero pad
    input  wire logic        i_s_axis_tuser,  // [0] command
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,  // [14:0] payload_address, zero pad
    output logic             o_m_axis_tuser   // [0] ok
);

    localparam int WORDS = HEAP_BYTES / 8;
    localparam int AW    = $clog2(WORDS);
    localparam int TW    = $clog2(HEAP_BYTES) + 1;

    t_item         in_item;
    logic          ctrl_idle, ctrl_done, take;
    t_result       ctrl_res;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_widx, mem_ridx;
    logic [TW-1:0] mem_wdata, mem_rdata;

    logic    r_out_valid;
    t_result r_out;

    // unpack the incoming word
    assign in_item.command       = t_cmd'(i_s_axis_tuser);
    assign in_item.request_size  = i_s_axis_tdata[14:0];
    assign in_item.block_address = i_s_axis_tdata[29:15];

    assign o_s_axis_tready = ctrl_idle;

    // move a finished result into the output register when it is free or draining
    assign take = ctrl_done && (!r_out_valid || i_m_axis_tready);

    btnf_tag_ram #(
        .DEPTH (WORDS),
        .AW    (AW),
        .DW    (TW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_idx  (mem_widx),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_idx  (mem_ridx),
        .o_rd_data (mem_rdata)
    );

    btnf_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .AW         (AW),
        .TW         (TW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_axis_tvalid && ctrl_idle),
        .i_item      (in_item),
        .o_idle      (ctrl_idle),
        .o_done      (ctrl_done),
        .i_taken     (take),
        .o_result    (ctrl_res),
        .o_mem_we    (mem_we),
        .o_mem_widx  (mem_widx),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_ridx  (mem_ridx),
        .i_mem_rdata (mem_rdata)
    );

    // output register: hold until the sink takes the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= ctrl_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.payload_address};
    assign o_m_axis_tuser  = r_out.ok;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the boundary-tag next-fit allocator unit.
`timescale 1ns / 100ps
module testbench;
    import btnf_pkg::*;

    localparam int HEAP       = 32768;
    localparam int TAG_WORDS  = HEAP / 8;
    localparam int HEAP_LIMIT = HEAP & ~15;
    localparam int N_RANDOM   = 830;
    localparam longint CYCLE_LIMIT = 20000000;

    // Heap shadow: keeps its own tag store and rover, and queues the
    // expected result of each accepted word.
    class heap_shadow;
        int unsigned tags [TAG_WORDS];
        int unsigned rover;
        t_result     pending [$];
        int          errors;

        function new();
            foreach (tags[i]) tags[i] = 0;
            put(8, 17);
            put(16, 17);
            put(24, HEAP_LIMIT - 32);
            put(HEAP_LIMIT - 16, HEAP_LIMIT - 32);
            put(HEAP_LIMIT - 8, 1);
            rover  = FIRST_PAYLOAD;
            errors = 0;
        endfunction

        function int unsigned get(int unsigned a);
            return (a >> 3) < TAG_WORDS ? tags[a >> 3] : 1;
        endfunction

        function void put(int unsigned a, int unsigned v);
            if ((a >> 3) < TAG_WORDS) tags[a >> 3] = v;
        endfunction

        // Walk block headers from 'from' below 'lim' for a free block of 'need'.
        function int unsigned find_fit(int unsigned from, int unsigned lim,
                                       int unsigned need);
            int unsigned p, h, s;
            p = from;
            for (int n = 0; n < TAG_WORDS; n++) begin
                if (p >= lim || p < FIRST_PAYLOAD) break;
                h = get(p - 8);
                s = h & ~32'd7;
                if (s == 0 || p + s > HEAP_LIMIT) break;
                if (!h[0] && need <= s) return p;
                p += s;
            end
            return 0;
        endfunction

        function t_result alloc_block(int unsigned req);
            t_result r;
            int unsigned need, f, avail;
            r = '0;
            need = req <= 16 ? MIN_BLOCK : 16 * ((req + 31) / 16);
            if (rover >= HEAP_LIMIT || rover < FIRST_PAYLOAD) rover = FIRST_PAYLOAD;
            f = find_fit(rover, HEAP_LIMIT, need);
            if (f == 0 && rover != FIRST_PAYLOAD) f = find_fit(FIRST_PAYLOAD, rover, need);
            if (f == 0) return r;
            rover = f;
            avail = get(f - 8) & ~32'd7;
            if (avail - need >= MIN_BLOCK) begin
                put(f - 8, need | 1);
                put(f + need - 16, need | 1);
                put(f + need - 8, avail - need);
                put(f + avail - 16, avail - need);
            end else begin
                put(f - 8, avail | 1);
                put(f + avail - 16, avail | 1);
            end
            r.payload_address = f[14:0];
            r.ok = 1'b1;
            return r;
        endfunction

        function t_result free_block(int unsigned a);
            t_result r;
            int unsigned h, s, pf, ps, nxt, nh, ns, m, t;
            bit prev_free, next_free;
            r = '0;
            if ((a & 15) != 0 || a < FIRST_PAYLOAD) return r;
            h = get(a - 8);
            s = h & ~32'd7;
            if (!h[0] || s < MIN_BLOCK || a + s > HEAP_LIMIT) return r;
            if (a < rover) rover = a;
            put(a - 8, s);
            put(a + s - 16, s);
            pf = get(a - 16);
            ps = pf & ~32'd7;
            prev_free = !pf[0] && ps != 0 && ps <= a - FIRST_PAYLOAD;
            nxt = a + s;
            nh = get(nxt - 8);
            ns = nh & ~32'd7;
            next_free = !nh[0] && ns != 0 && nxt + ns <= HEAP_LIMIT;
            m = a;
            if (!prev_free && next_free) begin
                t = s + ns;
                put(a - 8, t);
                put(a + t - 16, t);
            end else if (prev_free && !next_free) begin
                t = s + ps;
                put(a + s - 16, t);
                m = a - ps;
                put(m - 8, t);
            end else if (prev_free && next_free) begin
                t = s + ps + ns;
                put(nxt + ns - 16, t);
                m = a - ps;
                put(m - 8, t);
            end
            if (m < rover) rover = m;
            r.payload_address = m[14:0];
            r.ok = 1'b1;
            return r;
        endfunction

        // Note an accepted input word; hand back what it should produce.
        function t_result note_word(t_cmd cmd, logic [14:0] req, logic [14:0] addr);
            t_result r;
            r = (cmd == CMD_ALLOC) ? alloc_block(req) : free_block(addr);
            pending.push_back(r);
            return r;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_word(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result addr=%0d ok=%0b",
                                 got.payload_address, got.ok));
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok got %0b want %0b", got.ok, want.ok));
            if (got.payload_address !== want.payload_address)
                report($sformatf("address got %0d want %0d",
                                 got.payload_address, want.payload_address));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    heap_shadow  shadow;
    int unsigned live_blocks [$];
    int unsigned n_sent;
    bit          hold_off;
    bit          stim_done;
    longint      cycles;

    boundary_tag_next_fit_allocator_unit #(.HEAP_BYTES(HEAP)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [14:0] request_size, [29:15] block_address
        .i_s_axis_tuser  (s_tuser),   // [0] command
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [14:0] payload_address
        .o_m_axis_tuser  (m_tuser)    // [0] ok
    );

    always begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // Mostly short gaps, now and then a long one.
    function int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(t_cmd cmd, logic [14:0] req, logic [14:0] addr);
        t_result r;
        int idx;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, addr, req};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = shadow.note_word(cmd, req, addr);
        n_sent++;
        // Track live blocks so most frees hit a real allocation.
        if (r.ok && cmd == CMD_ALLOC) live_blocks.push_back(r.payload_address);
        if (r.ok && cmd == CMD_FREE) begin
            idx = -1;
            foreach (live_blocks[i]) if (live_blocks[i] == addr) idx = i;
            if (idx >= 0) live_blocks.delete(idx);
        end
        @(negedge clk);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic free_live(int unsigned pick);
        if (live_blocks.size() > 0)
            send_word(CMD_FREE, 15'($urandom), 15'(live_blocks[pick % live_blocks.size()]));
    endtask

    function logic [14:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 15'($urandom_range(0, 200));
        if (roll < 90) return 15'($urandom_range(200, 1500));
        if (roll < 97) return 15'($urandom_range(1500, 8000));
        return 15'($urandom);
    endfunction

    // Sender: directed corners, then a random mix of allocate and free.
    initial begin
        int roll;
        shadow    = new();
        n_sent    = 0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_ALLOC;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_word(CMD_ALLOC, 15'd0, 15'h7fff);
        send_word(CMD_ALLOC, 15'd16, 15'd0);
        send_word(CMD_ALLOC, 15'd17, 15'd0);
        send_word(CMD_ALLOC, 15'd48, 15'd0);
        send_word(CMD_ALLOC, 15'd1, 15'd0);
        send_word(CMD_ALLOC, 15'd100, 15'd0);
        send_word(CMD_ALLOC, 15'h7fff, 15'd0);          // no fit
        free_live(1);                                   // both neighbours allocated
        free_live(2);                                   // both neighbours allocated
        free_live(1);                                   // both free
        free_live(live_blocks.size() - 1);              // next free
        send_word(CMD_FREE, 15'd0, 15'd37);             // unaligned
        send_word(CMD_FREE, 15'd0, 15'd16);             // below first payload
        send_word(CMD_FREE, 15'd0, 15'd0);
        send_word(CMD_FREE, 15'h7fff, 15'h7ff0);        // next to the heap end, header not allocated
        send_word(CMD_FREE, 15'd0, 15'(live_blocks[0] + 4096)); // not allocated
        while (live_blocks.size() > 0) free_live(0);
        send_word(CMD_ALLOC, 15'd32704, 15'd0);         // takes the whole heap
        send_word(CMD_ALLOC, 15'd0, 15'd0);             // heap exhausted
        free_live(0);
        send_word(CMD_ALLOC, 15'd32000, 15'd0);         // splits, leaving a free rest
        free_live(0);

        for (int n = 0; n < N_RANDOM; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_word(CMD_ALLOC, pick_size(), 15'($urandom));
            else if (roll < 92 && live_blocks.size() > 0)
                free_live($urandom);
            else if (roll < 96) send_word(CMD_FREE, 15'($urandom), 15'($urandom));
            else send_word(CMD_FREE, 15'($urandom), 15'($urandom_range(2, 2047) * 16));
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Long receiver hold-off, so the output register and then the input stall.
    initial begin
        hold_off = 1'b0;
        wait (n_sent > 200);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
    end

    // Receiver: random ready, check each accepted result word.
    initial begin
        int wait_n;
        t_result got;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                wait_n = gap_len();
                if (wait_n > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n - 1) @(negedge clk);
                    @(negedge clk);
                end
                m_tready <= !hold_off;
            end
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                got.ok = m_tuser;
                got.payload_address = m_tdata[14:0];
                shadow.check_word(got);
            end
        end
    end

    // Run end and watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            if (stim_done && shadow.pending.size() == 0) begin
                repeat (100) @(posedge clk);
                if (shadow.errors == 0 && shadow.pending.size() == 0) begin
                    $display("TB_OK");
                end else begin
                    $display("TB_ERROR");
                end
                $finish;
            end
        end
    end

endmodule
